// ===== rtl/core/first_occurrence_search_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the first-occurrence search RTL
// ----------------------------------------------------------------------------
`ifndef FIRST_OCCURRENCE_SEARCH_DEFINES_SVH
`define FIRST_OCCURRENCE_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset
`define FOS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset
`define FOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fos_pkg.sv =====
// ----------------------------------------------------------------------------
// fos_pkg
// Types and constants shared by the first-occurrence search modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fos_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_BINARY = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;   // append the incoming word to the store
    logic start;  // capture key and set up search bounds
    logic probe;  // issue a store read at the current probe index
    logic step;   // compare read data and advance the search
    logic emit;   // load the result register
  } fos_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active; // search still has entries left to probe
  } fos_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/fos_in_if.sv =====
// ----------------------------------------------------------------------------
// fos_in_if
// Input channel: load or query words with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fos_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [fos_pkg::VALUE_W-1:0] value;
  logic                          last;

  modport source (output valid, kind, value, last, input ready);
  modport sink   (input valid, kind, value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fos_out_if.sv =====
// ----------------------------------------------------------------------------
// fos_out_if
// Output channel: one result word per query with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fos_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [fos_pkg::POS_W-1:0]  position;
  logic                       overflow;

  modport source (output valid, found, position, overflow, input ready);
  modport sink   (input valid, found, position, overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/first_occurrence_search.sv =====
// Load words: written straight into the element store while idle; a word that
//   finds the store full is dropped and flagged.
// Query words: each probe is a store read, then a compare, until no entries are left.
// One word is worked on at a time; a finished result waits in the output
//   register while further load words are taken.
// Synchronous reset: empty closed array, no drop flag, linear mode, no result.
// ----------------------------------------------------------------------------
// first_occurrence_search
// Loads an array of signed words and reports the first index matching a key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_occurrence_search #(
  parameter int DEPTH = 128
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  fos_in_if.sink     in_ch,
  fos_out_if.source  out_ch
);
  import fos_pkg::*;
  `include "first_occurrence_search_defines.svh"

  localparam int AW = $clog2(DEPTH);

  fos_cmd_t cmd;
  fos_sts_t sts;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  fos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fos_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_value  (in_ch.value),
    .in_last   (in_ch.last),
    .cmd       (cmd),
    .sts       (sts),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .found     (out_ch.found),
    .position  (out_ch.position),
    .overflow  (out_ch.overflow)
  );

  fos_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `FOS_ASSERT_NOW(a_step_after_probe, cmd.step, $past(cmd.probe), "compare without a store read")
  `FOS_ASSERT_NOW(a_probe_in_bounds, cmd.probe, sts.active, "store read past search bounds")
  `FOS_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, out_ch.valid, "result lost after emit")

endmodule

`default_nettype wire

// ===== rtl/core/fos_ram.sv =====
// ----------------------------------------------------------------------------
// fos_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fos_ctrl.sv =====
// ----------------------------------------------------------------------------
// fos_ctrl
// Sequencer: accepts words, steps the search through read/compare, emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fos_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_kind,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  input  wire fos_pkg::fos_sts_t sts,
  output      fos_pkg::fos_cmd_t cmd
);
  import fos_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_QUERY) begin
            cmd.start  = 1'b1;
            state_next = ST_READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (sts.active) begin
          cmd.probe  = 1'b1;
          state_next = ST_CMP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CMP: begin
        cmd.step   = 1'b1;
        state_next = ST_READ;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fos_dp.sv =====
// ----------------------------------------------------------------------------
// fos_dp
// Datapath: array bookkeeping, search bounds, key compare, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fos_dp #(
  parameter int DEPTH = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  input  wire logic signed [fos_pkg::VALUE_W-1:0] in_value,
  input  wire logic                          in_last,
  input  wire fos_pkg::fos_cmd_t             cmd,
  output      fos_pkg::fos_sts_t             sts,
  output      logic                          ram_we,
  output      logic [$clog2(DEPTH)-1:0]      ram_waddr,
  output      logic [fos_pkg::VALUE_W-1:0]   ram_wdata,
  output      logic                          ram_re,
  output      logic [$clog2(DEPTH)-1:0]      ram_raddr,
  input  wire logic [fos_pkg::VALUE_W-1:0]   ram_rdata,
  output      logic                          found,
  output      logic [fos_pkg::POS_W-1:0]     position,
  output      logic                          overflow
);
  import fos_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  // array bookkeeping
  logic          mode;
  logic [CW-1:0] count;
  logic          closed;
  logic          dropped;

  // search state
  logic signed [VALUE_W-1:0] key;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hi1;   // one past the upper bound
  logic [CW-1:0]             idx;   // linear scan index
  logic                      hit;
  logic [CW-1:0]             hit_idx;

  logic [CW-1:0]       eff_count;
  logic                eff_dropped;
  logic                full;
  logic [CW-1:0]       mid;
  logic [CW-1:0]       probe_idx;
  logic                eq;
  logic                lt;
  logic [PW-1:0]       hit_idx_ext;

  // a load into a closed array starts a new one
  assign eff_count   = closed ? '0 : count;
  assign eff_dropped = closed ? 1'b0 : dropped;
  assign full        = (eff_count == CW'(DEPTH));

  assign ram_we    = cmd.load && !full;
  assign ram_waddr = eff_count[AW-1:0];
  assign ram_wdata = in_value;

  assign mid       = lo + ((hi1 - lo - CW'(1)) >> 1);
  assign probe_idx = (mode == MODE_BINARY) ? mid : idx;
  assign ram_re    = cmd.probe;
  assign ram_raddr = probe_idx[AW-1:0];

  assign eq = ($signed(ram_rdata) == key);
  assign lt = (key < $signed(ram_rdata));

  always_comb begin
    if (mode == MODE_BINARY) begin
      sts.active = (lo < hi1);
    end else begin
      sts.active = (idx < count) && !hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_LINEAR;
      count   <= '0;
      closed  <= 1'b1;
      dropped <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (cmd.load) begin
        count   <= full ? eff_count : eff_count + CW'(1);
        dropped <= eff_dropped | full;
        closed  <= in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key     <= in_value;
      lo      <= '0;
      hi1     <= count;
      idx     <= '0;
      hit     <= 1'b0;
      hit_idx <= '0;
    end else if (cmd.step) begin
      if (mode == MODE_BINARY) begin
        // lower-bound search: keep narrowing left on a match
        if (eq) begin
          hit     <= 1'b1;
          hit_idx <= mid;
          hi1     <= mid;
        end else if (lt) begin
          hi1 <= mid;
        end else begin
          lo <= mid + CW'(1);
        end
      end else begin
        if (eq) begin
          hit     <= 1'b1;
          hit_idx <= idx;
        end else begin
          idx <= idx + CW'(1);
        end
      end
    end
  end

  assign hit_idx_ext = PW'(hit_idx);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found    <= hit;
      position <= hit_idx_ext[POS_W-1:0];
      overflow <= dropped;
    end
  end

endmodule

`default_nettype wire
